// File: src/frame_context_stacker_assert.svh
// Assertion macros for the frame context stacker checker.
`ifndef FRAME_CONTEXT_STACKER_ASSERT_SVH
`define FRAME_CONTEXT_STACKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define FCS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame_context_stacker: check failed");

// next-cycle implication
`define FCS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame_context_stacker: check failed");

`endif

// File: src/fcs_pkg.sv
// Shared constants, register codes and types of the frame context stacker.
package fcs_pkg;

	localparam int SAMPLE_W              = 16;
	localparam int NUM_CH_W              = 4;
	localparam int CTX_W                 = 3;
	localparam int STEP_W                = 4;
	localparam int CFG_W                 = 4;
	localparam int CFG_IDX_W             = 2;
	localparam int STEP_MAX              = (1 << STEP_W) - 1;
	localparam int MAX_CHANNELS_DEF      = 8;
	localparam int MAX_WINDOW_FRAMES_DEF = 8;

	localparam logic [CFG_IDX_W-1:0] REG_CHAN_NUM      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_CTX      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_CONTEXT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_STEP    = 2'd3;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic [NUM_CH_W-1:0] chan_num;
		logic [CTX_W-1:0]    left_ctx;
		logic [CTX_W-1:0]    right_context;
		logic [STEP_W-1:0]   frame_step;
	} cfg_t;

	typedef struct packed {
		sample_t value;
		logic    window_valid;
		logic    last;
	} result_t;

endpackage

// File: src/fcs_ifs.sv
// Valid/ready channel interfaces for samples in and stacked results out.
interface fcs_sample_if;
	logic              valid;
	logic              ready;
	fcs_pkg::sample_t  sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface fcs_result_if;
	logic              valid;
	logic              ready;
	fcs_pkg::sample_t  value;
	logic              window_valid;
	logic              last;

	modport source (output valid, output value, output window_valid, output last, input ready);
	modport sink (input valid, input value, input window_valid, input last, output ready);
endinterface

// File: src/frame_context_stacker.sv
// Top level of the frame context stacker: register file and channel hookup.
//
//   channel     dir   payload                          item
//   sample_ch   in    sample[15:0] signed              one channel value
//   result_ch   out   value[15:0], window_valid, last  one window element or a not-full flag
//   cfg_we/idx  in    cfg_wdata[3:0]                   register write, no read-back
//
// A sample that does not end a frame is written to the ring from idle. A frame end
// passes through a decide state, then emits one result per cycle while the output
// is not stalled (window samples, read through the single read port of the ring
// memory, or one not-full item); the result register lets the next sample in while
// the last result waits. The first frame after reset copies each padded sample with
// a read, then a write back. Reset empties the ring at once; no clearing pass. Output
// stalls hold the emit sequence in place.
module frame_context_stacker #(
	parameter int MAX_CHANNELS      = fcs_pkg::MAX_CHANNELS_DEF,
	parameter int MAX_WINDOW_FRAMES = fcs_pkg::MAX_WINDOW_FRAMES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	fcs_sample_if.sink                      sample_ch,
	fcs_result_if.source                    result_ch,
	input  logic                            cfg_we,
	input  logic [fcs_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [fcs_pkg::CFG_W-1:0]       cfg_wdata
);

	fcs_pkg::cfg_t    cfg_q;
	fcs_pkg::result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chan_num      <= fcs_pkg::NUM_CH_W'(1);
			cfg_q.left_ctx      <= '0;
			cfg_q.right_context <= '0;
			cfg_q.frame_step    <= fcs_pkg::STEP_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				fcs_pkg::REG_CHAN_NUM:      cfg_q.chan_num      <= cfg_wdata[fcs_pkg::NUM_CH_W-1:0];
				fcs_pkg::REG_LEFT_CTX:      cfg_q.left_ctx      <= cfg_wdata[fcs_pkg::CTX_W-1:0];
				fcs_pkg::REG_RIGHT_CONTEXT: cfg_q.right_context <= cfg_wdata[fcs_pkg::CTX_W-1:0];
				fcs_pkg::REG_FRAME_STEP:    cfg_q.frame_step    <= cfg_wdata[fcs_pkg::STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	fcs_ctrl #(
		.MAX_CHANNELS      (MAX_CHANNELS),
		.MAX_WINDOW_FRAMES (MAX_WINDOW_FRAMES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (sample_ch.valid),
		.in_ready  (sample_ch.ready),
		.in_sample (sample_ch.sample),
		.out_valid (result_ch.valid),
		.out_ready (result_ch.ready),
		.out_res   (res)
	);

	assign result_ch.value        = res.value;
	assign result_ch.window_valid = res.window_valid;
	assign result_ch.last         = res.last;

endmodule

// File: src/fcs_ctrl.sv
// Ring memory and sequencer: push, first-frame padding, window emit and drop.
module fcs_ctrl #(
	parameter int MAX_CHANNELS      = fcs_pkg::MAX_CHANNELS_DEF,
	parameter int MAX_WINDOW_FRAMES = fcs_pkg::MAX_WINDOW_FRAMES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fcs_pkg::cfg_t     cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  fcs_pkg::sample_t  in_sample,
	output logic              out_valid,
	input  logic              out_ready,
	output fcs_pkg::result_t  out_res
);

	localparam int DEPTH = MAX_CHANNELS * MAX_WINDOW_FRAMES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW    = AW + 1;
	localparam int FW    = $clog2(DEPTH + 1);
	localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CHW   = $clog2(MAX_CHANNELS + 1);
	localparam int FRW   = $clog2(MAX_WINDOW_FRAMES + 1);
	localparam int NXW   = (CHW > fcs_pkg::NUM_CH_W) ? CHW : fcs_pkg::NUM_CH_W;
	localparam int FXW   = (FRW > fcs_pkg::NUM_CH_W) ? FRW : fcs_pkg::NUM_CH_W;
	localparam int DW    = $clog2(fcs_pkg::STEP_MAX * MAX_CHANNELS + 1);
	localparam int DFW   = (DW > FW) ? DW : FW;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PAD_RD = 3'd1;
	localparam logic [2:0] ST_PAD_WR = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_EMIT   = 3'd4;

	function automatic logic [AW-1:0] wrap(input logic [PW-1:0] x);
		logic [PW-1:0] y;
		y = (x >= PW'(DEPTH)) ? x - PW'(DEPTH) : x;
		return y[AW-1:0];
	endfunction

	logic [fcs_pkg::SAMPLE_W-1:0] ring_mem [DEPTH];
	logic [fcs_pkg::SAMPLE_W-1:0] rd_q;

	logic [2:0]    state_q, state_d;
	logic [AW-1:0] head_q, head_d;
	logic [FW-1:0] fill_q, fill_d;
	logic [CW-1:0] cc_q, cc_d;
	logic          seen_q, seen_d;
	logic [FW-1:0] pad_cnt_q, pad_cnt_d;
	logic [AW-1:0] base_q, base_d;
	logic [FW-1:0] idx_q, idx_d;
	logic          emit_full_q, emit_full_d;
	logic          ov_q, ov_d;
	logic          wv_q, wv_d;
	logic          last_q, last_d;

	logic [NXW-1:0] ncx;
	logic [FXW-1:0] frx, lx, pad_lim;
	logic [CHW-1:0] ch_eff, count;
	logic [FRW-1:0] fr_eff, pad_fr;
	logic [fcs_pkg::STEP_W-1:0] step_eff;
	logic [FW-1:0]  window, pad_total;
	logic [DW-1:0]  drop;

	logic          push_full;
	logic [AW-1:0] push_addr, push_head, src_addr, emit_addr;
	logic [FW-1:0] push_fill;
	logic          emit_last, can_load;

	logic                         mem_we, mem_re;
	logic [AW-1:0]                mem_waddr, mem_raddr;
	logic [fcs_pkg::SAMPLE_W-1:0] mem_wdata;

	// effective register values
	always_comb begin
		ncx = NXW'(cfg.chan_num);
		if (ncx == '0)
			ch_eff = CHW'(1);
		else if (ncx > NXW'(MAX_CHANNELS))
			ch_eff = CHW'(MAX_CHANNELS);
		else
			ch_eff = CHW'(ncx);

		frx = FXW'(cfg.left_ctx) + FXW'(cfg.right_context) + FXW'(1);
		fr_eff = (frx > FXW'(MAX_WINDOW_FRAMES)) ? FRW'(MAX_WINDOW_FRAMES) : FRW'(frx);

		lx      = FXW'(cfg.left_ctx);
		pad_lim = FXW'(fr_eff) - FXW'(1);
		pad_fr  = (lx > pad_lim) ? FRW'(pad_lim) : FRW'(lx);

		step_eff  = (cfg.frame_step == '0) ? fcs_pkg::STEP_W'(1) : cfg.frame_step;
		window    = FW'(ch_eff) * FW'(fr_eff);
		pad_total = FW'(pad_fr) * FW'(ch_eff);
		drop      = DW'(step_eff) * DW'(ch_eff);
		count     = CHW'(cc_q) + CHW'(1);
	end

	// ring push: oldest sample is dropped when the ring already holds a window
	always_comb begin
		push_full = (fill_q >= window);
		if (push_full) begin
			push_addr = wrap(PW'(head_q) + PW'(window));
			push_head = wrap(PW'(head_q) + PW'(1));
			push_fill = window;
		end else begin
			push_addr = wrap(PW'(head_q) + PW'(fill_q));
			push_head = head_q;
			push_fill = fill_q + FW'(1);
		end
		// padding copies the sample one frame behind the write position
		src_addr  = wrap(PW'(push_addr) + PW'(DEPTH) - PW'(ch_eff));
		emit_addr = wrap(PW'(base_q) + PW'(idx_q));
		emit_last = (idx_q == window - FW'(1));
		can_load  = !ov_q || out_ready;
	end

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		fill_d      = fill_q;
		cc_d        = cc_q;
		seen_d      = seen_q;
		pad_cnt_d   = pad_cnt_q;
		base_d      = base_q;
		idx_d       = idx_q;
		emit_full_d = emit_full_q;
		ov_d        = ov_q;
		wv_d        = wv_q;
		last_d      = last_q;
		mem_we      = 1'b0;
		mem_waddr   = push_addr;
		mem_wdata   = in_sample;
		mem_re      = 1'b0;
		mem_raddr   = emit_addr;

		if (ov_q && out_ready)
			ov_d = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					mem_we = 1'b1;
					head_d = push_head;
					fill_d = push_fill;
					if (count < ch_eff) begin
						cc_d = CW'(count);
					end else begin
						cc_d = '0;
						if (!seen_q) begin
							seen_d    = 1'b1;
							pad_cnt_d = pad_total;
							state_d   = (pad_total == '0) ? ST_DECIDE : ST_PAD_RD;
						end else begin
							state_d = ST_DECIDE;
						end
					end
				end
			end
			ST_PAD_RD: begin
				if (!ov_q) begin
					mem_re    = 1'b1;
					mem_raddr = src_addr;
					state_d   = ST_PAD_WR;
				end
			end
			ST_PAD_WR: begin
				mem_we    = 1'b1;
				mem_wdata = rd_q;
				head_d    = push_head;
				fill_d    = push_fill;
				pad_cnt_d = pad_cnt_q - FW'(1);
				state_d   = (pad_cnt_q == FW'(1)) ? ST_DECIDE : ST_PAD_RD;
			end
			ST_DECIDE: begin
				emit_full_d = push_full;
				base_d      = head_q;
				idx_d       = '0;
				if (push_full) begin
					if (DFW'(drop) >= DFW'(fill_q)) begin
						fill_d = '0;
					end else begin
						head_d = wrap(PW'(head_q) + PW'(drop));
						fill_d = fill_q - FW'(drop);
					end
				end
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (can_load) begin
					ov_d = 1'b1;
					if (emit_full_q) begin
						mem_re = 1'b1;
						wv_d   = 1'b1;
						last_d = emit_last;
						idx_d  = idx_q + FW'(1);
						if (emit_last)
							state_d = ST_IDLE;
					end else begin
						wv_d    = 1'b0;
						last_d  = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// read data register doubles as the result value register
	always_ff @(posedge clk) begin
		if (mem_we)
			ring_mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_q <= ring_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			fill_q      <= '0;
			cc_q        <= '0;
			seen_q      <= 1'b0;
			pad_cnt_q   <= '0;
			base_q      <= '0;
			idx_q       <= '0;
			emit_full_q <= 1'b0;
			ov_q        <= 1'b0;
			wv_q        <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			fill_q      <= fill_d;
			cc_q        <= cc_d;
			seen_q      <= seen_d;
			pad_cnt_q   <= pad_cnt_d;
			base_q      <= base_d;
			idx_q       <= idx_d;
			emit_full_q <= emit_full_d;
			ov_q        <= ov_d;
			wv_q        <= wv_d;
			last_q      <= last_d;
		end
	end

	assign in_ready             = (state_q == ST_IDLE);
	assign out_valid            = ov_q;
	assign out_res.value        = wv_q ? fcs_pkg::sample_t'(rd_q) : fcs_pkg::sample_t'(0);
	assign out_res.window_valid = wv_q;
	assign out_res.last         = last_q;

endmodule

// File: src/fcs_checker.sv
// Port-level checks of the frame context stacker, bound to the top level.
`include "frame_context_stacker_assert.svh"

module fcs_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input fcs_pkg::sample_t out_value,
	input logic             out_window_valid,
	input logic             out_last
);

	// a not-full item is always alone and carries zero
	`FCS_ASSERT_NOW(a_notfull_last, out_valid && !out_window_valid, out_last)
	`FCS_ASSERT_NOW(a_notfull_zero, out_valid && !out_window_valid, out_value == '0)
	// no sample is taken while a window is still being emitted
	`FCS_ASSERT_NOW(a_no_in_mid_window, out_valid && !out_last, !in_ready)
	`FCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(out_value) && $stable(out_window_valid) && $stable(out_last))

endmodule

bind frame_context_stacker fcs_checker u_fcs_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_ready         (sample_ch.ready),
	.out_valid        (result_ch.valid),
	.out_ready        (result_ch.ready),
	.out_value        (result_ch.value),
	.out_window_valid (result_ch.window_valid),
	.out_last         (result_ch.last)
);

// File: tb/tb.sv
// Self-checking testbench for frame_context_stacker: random samples, predicted windows.
`timescale 1ns / 100ps

module tb;

	localparam int MAX_CH     = fcs_pkg::MAX_CHANNELS_DEF;
	localparam int MAX_FRAMES = fcs_pkg::MAX_WINDOW_FRAMES_DEF;
	localparam int RING_SIZE  = MAX_CH * MAX_FRAMES;
	localparam int IDLE_LIMIT = 3000;
	localparam int SETTLE     = 8;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [fcs_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [fcs_pkg::CFG_W-1:0] cfg_wdata;

	fcs_sample_if s_ch();
	fcs_result_if r_ch();

	frame_context_stacker uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_ch(s_ch),
		.result_ch(r_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// shadow of the block
	fcs_pkg::cfg_t cfg;
	logic [fcs_pkg::SAMPLE_W-1:0] ring [RING_SIZE];
	int ring_head;
	int ring_fill;
	int chan_cnt;
	bit seen_first;

	fcs_pkg::sample_t sample_q[$];
	fcs_pkg::result_t stacked_q[$];
	bit in_busy;
	int idle_in_pct;
	int stall_out_pct;

	int errors;
	int n_samples;
	int n_elems;
	int n_notfull;
	int n_settings;
	int idle_cycles;

	function automatic int ch_of(input int n);
		if (n == 0)
			return 1;
		if (n > MAX_CH)
			return MAX_CH;
		return n;
	endfunction

	function automatic int frames_of(input int l, input int r);
		int f;
		f = l + r + 1;
		if (f > MAX_FRAMES)
			f = MAX_FRAMES;
		return f;
	endfunction

	task automatic ring_push(input logic [fcs_pkg::SAMPLE_W-1:0] v, input int window);
		if (ring_fill >= window) begin
			ring_head = (ring_head + 1) % RING_SIZE;
			ring_fill = window - 1;
		end
		ring[(ring_head + ring_fill) % RING_SIZE] = v;
		ring_fill++;
	endtask

	task automatic stack_sample(input fcs_pkg::sample_t smp);
		int ch, frames, window, cnt, pad, drop, back, i, k;
		logic [fcs_pkg::SAMPLE_W-1:0] frame_copy [MAX_CH];
		fcs_pkg::result_t r;
		ch = ch_of(int'(cfg.chan_num));
		frames = frames_of(int'(cfg.left_ctx), int'(cfg.right_context));
		window = ch * frames;
		ring_push(smp, window);
		cnt = chan_cnt + 1;
		if (cnt < ch) begin
			chan_cnt = cnt;
			return;
		end
		chan_cnt = 0;
		if (!seen_first) begin
			// pad past context with copies of the first frame
			pad = int'(cfg.left_ctx);
			if (pad > frames - 1)
				pad = frames - 1;
			for (i = 0; i < ch; i++) begin
				back = (ring_fill >= ch) ? ring_fill - ch + i : i;
				frame_copy[i] = ring[(ring_head + back) % RING_SIZE];
			end
			for (k = 0; k < pad; k++)
				for (i = 0; i < ch; i++)
					ring_push(frame_copy[i], window);
			seen_first = 1;
		end
		if (ring_fill >= window) begin
			for (i = 0; i < window; i++) begin
				r.value = ring[(ring_head + i) % RING_SIZE];
				r.window_valid = 1'b1;
				r.last = (i == window - 1);
				stacked_q.push_back(r);
			end
			drop = ((cfg.frame_step == 0) ? 1 : int'(cfg.frame_step)) * ch;
			if (drop >= ring_fill) begin
				ring_fill = 0;
			end else begin
				ring_head = (ring_head + drop) % RING_SIZE;
				ring_fill -= drop;
			end
		end else begin
			r.value = '0;
			r.window_valid = 1'b0;
			r.last = 1'b1;
			stacked_q.push_back(r);
		end
	endtask

	task automatic report(input string msg);
		errors++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic check_result();
		fcs_pkg::result_t exp;
		if (stacked_q.size() == 0) begin
			report($sformatf("unexpected result value=%h wv=%b last=%b",
				r_ch.value, r_ch.window_valid, r_ch.last));
			return;
		end
		exp = stacked_q.pop_front();
		if (r_ch.value !== exp.value)
			report($sformatf("value %h, expected %h", r_ch.value, exp.value));
		if (r_ch.window_valid !== exp.window_valid)
			report($sformatf("window_valid %b, expected %b", r_ch.window_valid,
				exp.window_valid));
		if (r_ch.last !== exp.last)
			report($sformatf("last %b, expected %b", r_ch.last, exp.last));
		if (exp.window_valid)
			n_elems++;
		else
			n_notfull++;
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// monitor: results first, then the sample taken on the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (r_ch.valid && r_ch.ready)
				check_result();
			if (s_ch.valid && s_ch.ready) begin
				stack_sample(s_ch.sample);
				void'(sample_q.pop_front());
				in_busy = 0;
				n_samples++;
			end
		end
	end

	// driver
	always @(negedge clk) begin
		if (!in_busy) begin
			if (sample_q.size() > 0 && $urandom_range(99) >= idle_in_pct) begin
				s_ch.valid <= 1'b1;
				s_ch.sample <= sample_q[0];
				in_busy = 1;
			end else begin
				s_ch.valid <= 1'b0;
			end
		end
		r_ch.ready <= ($urandom_range(99) >= stall_out_pct);
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (s_ch.valid && s_ch.ready) || (r_ch.valid && r_ch.ready) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("FAIL frame_context_stacker");
			$finish;
		end
	end

	task automatic write_reg(input logic [fcs_pkg::CFG_IDX_W-1:0] idx,
		input logic [fcs_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		unique case (idx)
			fcs_pkg::REG_CHAN_NUM:      cfg.chan_num = val[fcs_pkg::NUM_CH_W-1:0];
			fcs_pkg::REG_LEFT_CTX:      cfg.left_ctx = val[fcs_pkg::CTX_W-1:0];
			fcs_pkg::REG_RIGHT_CONTEXT: cfg.right_context = val[fcs_pkg::CTX_W-1:0];
			fcs_pkg::REG_FRAME_STEP:    cfg.frame_step = val[fcs_pkg::STEP_W-1:0];
			default: ;
		endcase
	endtask

	// upper bit of the 4-bit context writes is random; the block keeps only the low 3 bits
	task automatic setup(input int nc, input int lc, input int rc, input int st);
		write_reg(fcs_pkg::REG_CHAN_NUM, 4'(nc));
		write_reg(fcs_pkg::REG_LEFT_CTX, {1'($urandom_range(1)), 3'(lc)});
		write_reg(fcs_pkg::REG_RIGHT_CONTEXT, {1'($urandom_range(1)), 3'(rc)});
		write_reg(fcs_pkg::REG_FRAME_STEP, 4'(st));
		@(negedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic set_idling(input idle_mode_t mode);
		unique case (mode)
			IDLE_NONE:     begin idle_in_pct = 0;  stall_out_pct = 0;  end
			IDLE_SENDER:   begin idle_in_pct = 56; stall_out_pct = 0;  end
			IDLE_RECEIVER: begin idle_in_pct = 0;  stall_out_pct = 56; end
			IDLE_BOTH:     begin idle_in_pct = 18; stall_out_pct = 18; end
		endcase
	endtask

	task automatic wait_idle();
		while (sample_q.size() != 0 || in_busy || stacked_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic queue_random(input int n);
		int i;
		for (i = 0; i < n; i++)
			sample_q.push_back(fcs_pkg::sample_t'($urandom));
	endtask

	initial begin
		int phase, nsamp, half, rand_total, nc, lc, rc, st;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		s_ch.valid = 1'b0;
		s_ch.sample = '0;
		r_ch.ready = 1'b0;
		in_busy = 0;
		idle_in_pct = 0;
		stall_out_pct = 0;
		cfg.chan_num = 4'd1;
		cfg.left_ctx = 3'd0;
		cfg.right_context = 3'd0;
		cfg.frame_step = 4'd1;
		ring_head = 0;
		ring_fill = 0;
		chan_cnt = 0;
		seen_first = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// first frame padded, then full windows
		set_idling(IDLE_NONE);
		setup(3, 2, 1, 1);
		sample_q.push_back(fcs_pkg::sample_t'(16'h8000));
		sample_q.push_back(fcs_pkg::sample_t'(16'h7fff));
		sample_q.push_back(fcs_pkg::sample_t'(16'h0000));
		sample_q.push_back(fcs_pkg::sample_t'(16'hffff));
		sample_q.push_back(fcs_pkg::sample_t'(16'h0001));
		sample_q.push_back(fcs_pkg::sample_t'(16'h5555));
		sample_q.push_back(fcs_pkg::sample_t'(16'haaaa));
		sample_q.push_back(fcs_pkg::sample_t'(16'h8000));
		sample_q.push_back(fcs_pkg::sample_t'(16'h7fff));
		wait_idle();

		// zero channels, oversized context, zero step; window shrinks so ring overflows
		set_idling(IDLE_SENDER);
		setup(0, 7, 7, 0);
		sample_q.push_back(fcs_pkg::sample_t'(16'h0001));
		sample_q.push_back(fcs_pkg::sample_t'(16'h0002));
		sample_q.push_back(fcs_pkg::sample_t'(16'hfffe));
		sample_q.push_back(fcs_pkg::sample_t'(16'h8001));
		sample_q.push_back(fcs_pkg::sample_t'(16'h7ffe));
		wait_idle();

		// channels above max, huge step empties the ring
		set_idling(IDLE_RECEIVER);
		setup(15, 0, 0, 15);
		queue_random(8);
		wait_idle();

		// channel count lowered mid-frame
		set_idling(IDLE_BOTH);
		setup(4, 1, 1, 3);
		queue_random(2);
		wait_idle();
		setup(1, 1, 1, 3);
		queue_random(2);
		wait_idle();

		phase = 0;
		rand_total = 0;
		while (rand_total < 190) begin
			if (phase == 0) begin
				nc = 8; lc = 4; rc = 3; st = 1;
			end else if (phase == 1) begin
				nc = 1; lc = 0; rc = 0; st = 1;
			end else if ($urandom_range(9) < 7) begin
				nc = $urandom_range(8, 1);
				lc = $urandom_range(7);
				rc = $urandom_range(7 - lc);
				st = $urandom_range(8, 1);
			end else begin
				nc = $urandom_range(15);
				lc = $urandom_range(7);
				rc = $urandom_range(7);
				st = $urandom_range(15);
			end
			set_idling(idle_mode_t'(phase % 4));
			setup(nc, lc, rc, st);
			nsamp = (frames_of(lc, rc) + $urandom_range(3, 1)) * ch_of(nc);
			if (phase == 0)
				nsamp = 11 * MAX_CH;
			// sometimes leave a frame open into the next setting
			if ($urandom_range(2) == 0)
				nsamp += $urandom_range(ch_of(nc) - 1);
			if (phase == 2) begin
				half = nsamp / 2;
				queue_random(half);
				wait_idle();
				queue_random(nsamp - half);
			end else begin
				queue_random(nsamp);
			end
			wait_idle();
			rand_total += nsamp;
			phase++;
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (stacked_q.size() != 0)
			report($sformatf("%0d results never arrived", stacked_q.size()));
		$display("covered %0d samples under %0d register settings", n_samples, n_settings);
		$display("checked %0d window elements and %0d not-full results", n_elems, n_notfull);
		if (errors == 0)
			$display("PASS frame_context_stacker");
		else
			$display("FAIL frame_context_stacker");
		$finish;
	end

endmodule
